/* hdl/sliding_window_median_assert.svh */
// Assertion macros used by the checker file of the median filter.
`ifndef SLIDING_WINDOW_MEDIAN_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SWM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sliding_window_median: check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sliding_window_median: check failed");

`endif

/* hdl/swm_pkg.sv */
`timescale 1ns / 1ps

package swm_pkg;

  // Port widths fixed by the interface
  localparam int IN_W       = 32;
  localparam int OUT_W      = 33;
  localparam int WS_W       = 7;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Register map
  localparam logic [APB_ADDR_W-1:0] ADDR_WINDOW_SIZE  = 3'h0;
  localparam logic [WS_W-1:0]       WINDOW_SIZE_RESET = 7'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;   // latch the incoming beat
    logic remove;   // drop the oldest sample from the sorted cells
    logic insert;   // insert the new sample, write the ring
    logic replace;  // window was full: this beat replaces the oldest sample
    logic pick;     // register the two middle cells
    logic emit;     // load the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;       // window holds W samples
    logic last_fill;  // one more insert fills the window
    logic out_free;   // output register can take a result
  } status_t;

endpackage

/* hdl/sliding_window_median.sv */
`timescale 1ns / 1ps

// Running median filter. Each accepted sample beat enters a window of the last
// W samples (W = window_size, zero read as 1, clamped to MAX_WINDOW); once the
// window is full every beat returns twice the median (sum of the two middle
// samples, or twice the middle one for odd W) as a signed 33-bit value. While
// filling, beats return nothing. restart empties the window before the beat;
// writing window_size (APB offset 0, write only while idle) also empties it.
// A beat is worked through one step per cycle: ring read, removal of the
// oldest sample from the sorted cells (only once full), insertion, then middle
// pick and final add when the window is or becomes full. The input stalls
// until a beat's steps are done, so the next sample waits for the last one;
// a stalled output holds the final step until taken.
module sliding_window_median #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [swm_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [swm_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [swm_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                  pready,
  // sample channel
  input  logic                                  sample_valid,
  output logic                                  sample_stall,
  input  logic signed [swm_pkg::IN_W-1:0]       sample,
  input  logic                                  restart,
  // median channel
  output logic                                  median_valid,
  input  logic                                  median_stall,
  output logic signed [swm_pkg::OUT_W-1:0]      median_doubled
);

  swm_pkg::cmd_t              cmd;
  swm_pkg::status_t           st;
  logic                       addr_hit;
  logic                       cfg_we;
  logic [swm_pkg::WS_W-1:0]   window_size;

  // Register decode: word address only
  assign addr_hit = (paddr[swm_pkg::APB_ADDR_W-1:2] ==
                     swm_pkg::ADDR_WINDOW_SIZE[swm_pkg::APB_ADDR_W-1:2]);
  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite && pready && addr_hit;
  assign prdata   = addr_hit ? swm_pkg::APB_DATA_W'(window_size) : '0;

  swm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .st           (st),
    .cmd          (cmd)
  );

  swm_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .sample         (sample),
    .restart        (restart),
    .cfg_we         (cfg_we),
    .cfg_wdata      (pwdata[swm_pkg::WS_W-1:0]),
    .window_size    (window_size),
    .median_doubled (median_doubled),
    .median_valid   (median_valid),
    .median_stall   (median_stall)
  );

endmodule

/* hdl/swm_datapath.sv */
`timescale 1ns / 1ps

module swm_datapath #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  swm_pkg::cmd_t                        cmd,
  output swm_pkg::status_t                     st,
  input  logic [swm_pkg::IN_W-1:0]             sample,
  input  logic                                 restart,
  input  logic                                 cfg_we,
  input  logic [swm_pkg::WS_W-1:0]             cfg_wdata,
  output logic [swm_pkg::WS_W-1:0]             window_size,
  output logic signed [swm_pkg::OUT_W-1:0]     median_doubled,
  output logic                                 median_valid,
  input  logic                                 median_stall
);

  localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int FW = $clog2(MAX_WINDOW + 1);
  localparam int CW = (FW > swm_pkg::WS_W) ? FW : swm_pkg::WS_W;

  logic signed [SAMPLE_BITS-1:0] x_reg;
  logic signed [SAMPLE_BITS-1:0] old_val;
  logic signed [SAMPLE_BITS-1:0] lo_pick;
  logic signed [SAMPLE_BITS-1:0] hi_pick;
  logic signed [SAMPLE_BITS-1:0] lo_acc;
  logic signed [SAMPLE_BITS-1:0] hi_acc;
  logic [FW-1:0]                 fill;
  logic [IW-1:0]                 oldest;
  logic [FW-1:0]                 w_eff;
  logic [CW-1:0]                 ws_ext;
  logic [FW-1:0]                 n_ins;
  logic [IW-1:0]                 lo_idx;
  logic [IW-1:0]                 hi_idx;
  logic [IW-1:0]                 wr_addr;
  logic [FW-1:0]                 oldest_inc;

  logic signed [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] cells [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] rm_next [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] ins_next [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]         eq;
  logic [MAX_WINDOW-1:0]         gt;
  logic [MAX_WINDOW-1:0]         after;
  logic [MAX_WINDOW-1:0]         sel_lo;
  logic [MAX_WINDOW-1:0]         sel_hi;

  // Effective window: zero means one, clamp at the cell count
  assign ws_ext = CW'(window_size);
  always_comb begin
    if (ws_ext == '0) begin
      w_eff = FW'(1);
    end else if (ws_ext > CW'(MAX_WINDOW)) begin
      w_eff = FW'(MAX_WINDOW);
    end else begin
      w_eff = FW'(ws_ext);
    end
  end

  assign lo_idx     = IW'((w_eff - FW'(1)) >> 1);
  assign hi_idx     = IW'(w_eff >> 1);
  assign n_ins      = cmd.replace ? (fill - FW'(1)) : fill;
  assign wr_addr    = cmd.replace ? oldest : fill[IW-1:0];
  assign oldest_inc = FW'(oldest) + FW'(1);

  // Status
  assign st.full      = (fill == w_eff);
  assign st.last_fill = ((fill + FW'(1)) == w_eff);
  assign st.out_free  = !median_valid || !median_stall;

  // Per-cell compare and neighbor selection
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    assign eq[i]     = (FW'(i) < fill) && (cells[i] == old_val);
    assign gt[i]     = (FW'(i) < n_ins) && (cells[i] > x_reg);
    assign after[i]  = |eq[i:0];
    assign sel_lo[i] = (IW'(i) == lo_idx);
    assign sel_hi[i] = (IW'(i) == hi_idx);

    // removal closes the gap at and after the first matching cell
    if (i < MAX_WINDOW - 1) begin : g_rm
      assign rm_next[i] = after[i] ? cells[i+1] : cells[i];
    end else begin : g_rm_last
      assign rm_next[i] = cells[i];
    end

    // insertion opens a gap where the larger cells begin
    if (i == 0) begin : g_ins_first
      always_comb begin
        if (FW'(i) > n_ins) begin
          ins_next[i] = cells[i];
        end else if ((FW'(i) < n_ins) && !gt[i]) begin
          ins_next[i] = cells[i];
        end else begin
          ins_next[i] = x_reg;
        end
      end
    end else begin : g_ins
      always_comb begin
        if (FW'(i) > n_ins) begin
          ins_next[i] = cells[i];
        end else if ((FW'(i) < n_ins) && !gt[i]) begin
          ins_next[i] = cells[i];
        end else if (gt[i-1]) begin
          ins_next[i] = cells[i-1];
        end else begin
          ins_next[i] = x_reg;
        end
      end
    end
  end

  // Middle cell select, AND-OR over one-hot taps
  always_comb begin
    lo_acc = '0;
    hi_acc = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      lo_acc = lo_acc | (cells[i] & {SAMPLE_BITS{sel_lo[i]}});
      hi_acc = hi_acc | (cells[i] & {SAMPLE_BITS{sel_hi[i]}});
    end
  end

  // Sorted cells
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (cmd.remove) begin
        cells[i] <= rm_next[i];
      end else if (cmd.insert) begin
        cells[i] <= ins_next[i];
      end
    end
  end

  // Arrival ring: one write port, registered read at the oldest slot
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      ring[wr_addr] <= x_reg;
    end
    old_val <= ring[oldest];
  end

  // Sample latch and middle picks
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_reg <= sample[SAMPLE_BITS-1:0];
    end
    if (cmd.pick) begin
      lo_pick <= lo_acc;
      hi_pick <= hi_acc;
    end
    if (cmd.emit) begin
      median_doubled <= swm_pkg::OUT_W'(lo_pick) + swm_pkg::OUT_W'(hi_pick);
    end
  end

  // Window size register, fill count and oldest slot
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= swm_pkg::WINDOW_SIZE_RESET;
      fill        <= '0;
      oldest      <= '0;
    end else if (cfg_we) begin
      window_size <= cfg_wdata;
      fill        <= '0;
      oldest      <= '0;
    end else if (cmd.accept && restart) begin
      fill   <= '0;
      oldest <= '0;
    end else if (cmd.insert) begin
      if (cmd.replace) begin
        oldest <= (oldest_inc >= w_eff) ? '0 : IW'(oldest_inc);
      end else begin
        fill   <= fill + FW'(1);
        oldest <= '0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      median_valid <= 1'b0;
    end else if (cmd.emit) begin
      median_valid <= 1'b1;
    end else if (median_valid && !median_stall) begin
      median_valid <= 1'b0;
    end
  end

endmodule

/* hdl/swm_ctrl.sv */
`timescale 1ns / 1ps

module swm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  swm_pkg::status_t st,
  output swm_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE,
    PREP,
    REMOVE,
    INSERT,
    PICK,
    EMIT
  } state_t;

  state_t state;
  logic   replace;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      replace <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (sample_valid) begin
            state <= PREP;
          end
        end
        PREP: begin
          replace <= st.full;
          state   <= st.full ? REMOVE : INSERT;
        end
        REMOVE: begin
          state <= INSERT;
        end
        INSERT: begin
          state <= (replace || st.last_fill) ? PICK : IDLE;
        end
        PICK: begin
          state <= EMIT;
        end
        EMIT: begin
          if (st.out_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // Commands
  assign sample_stall = (state != IDLE);
  assign cmd.accept   = (state == IDLE) && sample_valid;
  assign cmd.remove   = (state == REMOVE);
  assign cmd.insert   = (state == INSERT);
  assign cmd.replace  = replace;
  assign cmd.pick     = (state == PICK);
  assign cmd.emit     = (state == EMIT) && st.out_free;

endmodule

/* hdl/swm_checker.sv */
`timescale 1ns / 1ps

`include "sliding_window_median_assert.svh"

module swm_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              sample_valid,
  input logic                              sample_stall,
  input logic                              median_valid,
  input logic                              median_stall,
  input logic signed [swm_pkg::OUT_W-1:0]  median_doubled
);

  // a stalled result beat holds
  `SWM_ASSERT_NEXT(a_out_hold, clk, rst, median_valid && median_stall, median_valid && $stable(median_doubled))

  // one sample at a time: busy right after a beat is taken
  `SWM_ASSERT_NEXT(a_busy_after_beat, clk, rst, sample_valid && !sample_stall, sample_stall)

  // a result only appears as the sample work finishes
  `SWM_ASSERT_NOW(a_result_from_work, clk, rst, $rose(median_valid), $past(sample_stall))

  // out of reset: idle and empty
  `SWM_ASSERT_NOW(a_reset_idle, clk, rst, $past(rst), !median_valid && !sample_stall)

endmodule

bind sliding_window_median swm_checker u_swm_checker (
  .clk            (clk),
  .rst            (rst),
  .sample_valid   (sample_valid),
  .sample_stall   (sample_stall),
  .median_valid   (median_valid),
  .median_stall   (median_stall),
  .median_doubled (median_doubled)
);
